>>> src/sgme_pkg.sv
// Shared types and constants of the spectral gate mask engine.
`default_nettype none

package sgme_pkg;

    // Field widths fixed by the data formats
    localparam int MAG_W     = 24;
    localparam int MASK_W    = 16;
    localparam int COEFF_W   = 17;
    localparam int FF_W      = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [MASK_W-1:0]  UNITY_MASK   = 16'h8000;
    localparam logic [COEFF_W-1:0] UNITY_COEFF  = 17'h10000;
    localparam logic [FF_W-1:0]    UNITY_WEIGHT = 16'd4096;
    localparam logic [MAG_W-1:0]   MAG_MAX      = 24'hFFFFFF;

    // Register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPEN_THRESHOLD = 3'd0,
        CFG_CLOSED_GAIN    = 3'd1,
        CFG_ATTACK_COEFF   = 3'd2,
        CFG_RELEASE_COEFF  = 3'd3,
        CFG_FREQ_FACTOR    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [MAG_W-1:0]   open_threshold;
        logic [MASK_W-1:0]  closed_gain;
        logic [COEFF_W-1:0] attack_coeff;
        logic [COEFF_W-1:0] release_coeff;
        logic [FF_W-1:0]    freq_factor;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        open_threshold: 24'd655,
        closed_gain:    16'd328,
        attack_coeff:   17'd65536,
        release_coeff:  17'd6554,
        freq_factor:    16'd4096
    };

    // Classification of one bin, made by the front end
    typedef struct packed {
        logic fresh;   // first frame since reset: stored state reads as reset value
        logic last;    // highest bin of the frame
    } item_flags_t;

endpackage

`default_nettype wire

>>> src/sgme_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sgme_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 513
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, data held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/sgme_fifo.sv
// Small flop-based queue between the front end and the back end.
`default_nettype none

module sgme_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = data_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> src/sgme_front.sv
// Front end: accepts magnitudes, numbers the bins and computes the threshold weight.
`default_nettype none

module sgme_front #(
    parameter int FFT_POINTS = 1024,
    parameter int BIN_COUNT  = 513,
    parameter int W_WIDTH    = 19
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    input  wire logic [sgme_pkg::MAG_W-1:0]         magnitude,
    input  wire logic [sgme_pkg::FF_W-1:0]          freq_factor,
    input  wire logic                               q_full,
    output logic                                    q_push,
    output logic      [sgme_pkg::MAG_W-1:0]         q_mag,
    output logic      [$clog2(BIN_COUNT)-1:0]       q_bin,
    output logic      [W_WIDTH-1:0]                 q_w,
    output sgme_pkg::item_flags_t                   q_flags
);

    localparam int BinW   = $clog2(BIN_COUNT);
    localparam int FftLog = $clog2(FFT_POINTS);
    localparam int PW     = BinW + 19;

    logic [BinW-1:0]         bin_cnt_reg, bin_cnt_next;
    logic                    fresh_reg;
    logic                    accept;
    logic                    is_last;
    logic signed [16:0]      delta;
    logic signed [BinW+1:0]  bin2;
    logic signed [PW-1:0]    wprod;
    logic [PW-1:0]           wround;
    logic signed [PW-1:0]    wadj;
    logic signed [PW-1:0]    wshift;
    logic [W_WIDTH-1:0]      wq;
    logic [W_WIDTH:0]        wsum;

    assign accept  = push && !q_full;
    assign is_last = (bin_cnt_reg == BinW'(BIN_COUNT - 1));

    // Weight: 1.0 + (freq_factor - 1.0) * 2 * bin / FFT_POINTS, truncated toward zero
    assign delta  = signed'({1'b0, freq_factor}) - signed'({1'b0, sgme_pkg::UNITY_WEIGHT});
    assign bin2   = signed'({1'b0, bin_cnt_reg, 1'b0});
    assign wprod  = delta * bin2;
    assign wround = wprod[PW-1] ? PW'(FFT_POINTS - 1) : '0;
    assign wadj   = wprod + signed'(wround);
    assign wshift = wadj >>> FftLog;
    assign wq     = wshift[W_WIDTH-1:0];
    assign wsum   = {wq[W_WIDTH-1], wq} + (W_WIDTH + 1)'(sgme_pkg::UNITY_WEIGHT);

    // Clamp a negative weight to zero
    assign q_w = wsum[W_WIDTH] ? '0 : wsum[W_WIDTH-1:0];

    assign q_push        = accept;
    assign q_mag         = magnitude;
    assign q_bin         = bin_cnt_reg;
    assign q_flags.fresh = fresh_reg;
    assign q_flags.last  = is_last;

    // Wrap the bin counter at the end of each frame
    assign bin_cnt_next = is_last ? '0 : bin_cnt_reg + BinW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_cnt_reg <= '0;
            fresh_reg   <= 1'b1;
        end
        else if (accept)
        begin
            bin_cnt_reg <= bin_cnt_next;
            if (is_last)
            begin
                fresh_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/sgme_back.sv
// Back end: gate and mask update per bin, median smoothing and the result queue.
`default_nettype none

module sgme_back #(
    parameter int BIN_COUNT = 513,
    parameter int W_WIDTH   = 19
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire sgme_pkg::cfg_t                 cfg,
    input  wire logic                           q_empty,
    output logic                                q_pop,
    input  wire logic [sgme_pkg::MAG_W-1:0]     q_mag,
    input  wire logic [$clog2(BIN_COUNT)-1:0]   q_bin,
    input  wire logic [W_WIDTH-1:0]             q_w,
    input  wire sgme_pkg::item_flags_t          q_flags,
    input  wire logic                           pop,
    output logic                                empty,
    output logic      [$clog2(BIN_COUNT)-1:0]   bin_index,
    output logic      [sgme_pkg::MASK_W-1:0]    mask_value,
    output logic                                gate_state,
    output logic                                frame_end
);

    localparam int BinW    = $clog2(BIN_COUNT);
    localparam int MagW    = sgme_pkg::MAG_W;
    localparam int MaskW   = sgme_pkg::MASK_W;
    localparam int CoeffW  = sgme_pkg::COEFF_W;
    localparam int TW      = MagW + W_WIDTH;
    localparam int CmpW    = TW - 9;
    localparam int EntryW  = MaskW + 1;
    localparam int OqAw    = 2;
    localparam int OqDepth = 1 << OqAw;
    localparam int OqCw    = OqAw + 1;

    function automatic logic [MaskW-1:0] med3(
        input logic [MaskW-1:0] a,
        input logic [MaskW-1:0] b,
        input logic [MaskW-1:0] c
    );
        logic [MaskW-1:0] lo;
        logic [MaskW-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (c < lo) ? lo : ((c > hi) ? hi : c);
    endfunction

    logic                  advance;
    logic [TW-1:0]         prod_in;
    logic [EntryW-1:0]     rd_data;
    logic [EntryW-1:0]     wr_data;
    logic                  wr_en;

    // Stage 1: stored state arrives, threshold product ready
    logic                  s1_valid_reg;
    logic [MagW-1:0]       s1_mag_reg;
    logic [BinW-1:0]       s1_bin_reg;
    sgme_pkg::item_flags_t s1_flags_reg;
    logic [TW-1:0]         s1_prod_reg;

    logic                  cur_open;
    logic [MaskW-1:0]      cur_mask;
    logic                  above_open;
    logic [TW+2:0]         prod7;
    logic [CmpW-1:0]       close_lvl;
    logic [MagW:0]         mag_inc;
    logic [MagW+4:0]       mag10;
    logic                  below_close;
    logic                  new_open;
    logic [MaskW-1:0]      closed_tgt;
    logic [MaskW-1:0]      tgt;
    logic [CoeffW-1:0]     coeff_raw;
    logic [CoeffW-1:0]     coeff;
    logic signed [MaskW+1:0] diff;

    // Stage 2: mask step
    logic                    s2_valid_reg;
    logic [BinW-1:0]         s2_bin_reg;
    logic                    s2_last_reg;
    logic                    s2_open_reg;
    logic [MaskW-1:0]        s2_cur_reg;
    logic signed [MaskW+1:0] s2_diff_reg;
    logic [CoeffW-1:0]       s2_coeff_reg;

    logic signed [35:0]    step_prod;
    logic signed [35:0]    step_adj;
    logic signed [35:0]    step_sh;
    logic [MaskW-1:0]      new_mask;

    // Stage 3: median window and result emission
    logic                  s3_valid_reg;
    logic [BinW-1:0]       s3_bin_reg;
    logic                  s3_last_reg;
    logic                  s3_open_reg;
    logic [MaskW-1:0]      s3_mask_reg;
    logic [MaskW-1:0]      win0_reg;
    logic [MaskW-1:0]      win1_reg;
    logic                  prev_open_reg;

    logic                  emit_prev;
    logic                  emit_last;
    logic                  push_prev;
    logic                  push_last;
    logic [BinW-1:0]       prev_bin;
    logic [MaskW-1:0]      prev_mask;

    // Result queue
    logic [BinW-1:0]       oq_bin_reg  [OqDepth];
    logic [MaskW-1:0]      oq_mask_reg [OqDepth];
    logic                  oq_open_reg [OqDepth];
    logic                  oq_end_reg  [OqDepth];
    logic [OqAw-1:0]       oq_wr_ptr_reg;
    logic [OqAw-1:0]       oq_rd_ptr_reg;
    logic [OqAw-1:0]       oq_wr_ptr2;
    logic [OqCw-1:0]       oq_count_reg, oq_count_next;
    logic                  pop_ok;

    // Move the whole pipeline only while the result queue has room for two
    assign advance = (oq_count_reg <= OqCw'(OqDepth - 2));
    assign q_pop   = advance && !q_empty;
    assign prod_in = TW'(cfg.open_threshold) * TW'(q_w);

    sgme_ram #(
        .WIDTH (EntryW),
        .DEPTH (BIN_COUNT)
    ) u_state_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s2_bin_reg),
        .wdata (wr_data),
        .re    (q_pop),
        .raddr (q_bin),
        .rdata (rd_data)
    );

    // Stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= q_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_mag_reg   <= q_mag;
            s1_bin_reg   <= q_bin;
            s1_flags_reg <= q_flags;
            s1_prod_reg  <= prod_in;
        end
    end

    // Stored state reads as reset value during the first frame
    assign cur_open = s1_flags_reg.fresh ? 1'b0 : rd_data[EntryW-1];
    assign cur_mask = s1_flags_reg.fresh ? sgme_pkg::UNITY_MASK : rd_data[MaskW-1:0];

    // Open when above threshold; close when below 0.7 of it (saturated)
    assign above_open  = CmpW'(s1_mag_reg) > CmpW'(s1_prod_reg[TW-1:12]);
    assign prod7       = {s1_prod_reg, 3'b000} - {3'b000, s1_prod_reg};
    assign close_lvl   = prod7[TW+2:12];
    assign mag_inc     = {1'b0, s1_mag_reg} + (MagW + 1)'(1);
    assign mag10       = {1'b0, mag_inc, 3'b000} + {3'b000, mag_inc, 1'b0};
    assign below_close = (CmpW'(mag10) <= close_lvl) && (s1_mag_reg != sgme_pkg::MAG_MAX);
    assign new_open    = cur_open ? !below_close : above_open;

    // Pick target and attack or release coefficient
    assign closed_tgt = (cfg.closed_gain > sgme_pkg::UNITY_MASK) ? sgme_pkg::UNITY_MASK
                                                                 : cfg.closed_gain;
    assign tgt        = new_open ? sgme_pkg::UNITY_MASK : closed_tgt;
    assign coeff_raw  = (tgt > cur_mask) ? cfg.attack_coeff : cfg.release_coeff;
    assign coeff      = (coeff_raw > sgme_pkg::UNITY_COEFF) ? sgme_pkg::UNITY_COEFF : coeff_raw;
    assign diff       = signed'({2'b00, tgt}) - signed'({2'b00, cur_mask});

    // Stage 2 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            s2_bin_reg   <= s1_bin_reg;
            s2_last_reg  <= s1_flags_reg.last;
            s2_open_reg  <= new_open;
            s2_cur_reg   <= cur_mask;
            s2_diff_reg  <= diff;
            s2_coeff_reg <= coeff;
        end
    end

    // Step the mask toward the target, quotient truncated toward zero
    assign step_prod = s2_diff_reg * signed'({1'b0, s2_coeff_reg});
    assign step_adj  = step_prod + (step_prod[35] ? 36'sd65535 : 36'sd0);
    assign step_sh   = step_adj >>> 16;
    assign new_mask  = s2_cur_reg + step_sh[MaskW-1:0];

    // Write back the updated gate and mask
    assign wr_en   = advance && s2_valid_reg;
    assign wr_data = {s2_open_reg, new_mask};

    // Stage 3 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg)
        begin
            s3_bin_reg  <= s2_bin_reg;
            s3_last_reg <= s2_last_reg;
            s3_open_reg <= s2_open_reg;
            s3_mask_reg <= new_mask;
        end
    end

    // Emit the previous bin (median, raw for bin 0) and, on the last bin, the last bin itself
    assign emit_prev = s3_valid_reg && (s3_bin_reg != '0);
    assign emit_last = s3_valid_reg && s3_last_reg;
    assign push_prev = advance && emit_prev;
    assign push_last = advance && emit_last;
    assign prev_bin  = s3_bin_reg - BinW'(1);
    assign prev_mask = (s3_bin_reg == BinW'(1)) ? win1_reg
                                                : med3(win0_reg, win1_reg, s3_mask_reg);

    // Shift the median window
    always_ff @(posedge clk)
    begin
        if (advance && s3_valid_reg)
        begin
            win0_reg      <= win1_reg;
            win1_reg      <= s3_mask_reg;
            prev_open_reg <= s3_open_reg;
        end
    end

    // Result queue: up to two pushes and one pop per cycle
    assign empty      = (oq_count_reg == '0);
    assign pop_ok     = pop && !empty;
    assign oq_wr_ptr2 = oq_wr_ptr_reg + OqAw'(push_prev);
    assign oq_count_next = oq_count_reg + OqCw'(push_prev) + OqCw'(push_last) - OqCw'(pop_ok);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            oq_wr_ptr_reg <= oq_wr_ptr2 + OqAw'(push_last);
            oq_rd_ptr_reg <= oq_rd_ptr_reg + OqAw'(pop_ok);
            oq_count_reg  <= oq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_prev)
        begin
            oq_bin_reg[oq_wr_ptr_reg]  <= prev_bin;
            oq_mask_reg[oq_wr_ptr_reg] <= prev_mask;
            oq_open_reg[oq_wr_ptr_reg] <= prev_open_reg;
            oq_end_reg[oq_wr_ptr_reg]  <= 1'b0;
        end
        if (push_last)
        begin
            oq_bin_reg[oq_wr_ptr2]  <= s3_bin_reg;
            oq_mask_reg[oq_wr_ptr2] <= s3_mask_reg;
            oq_open_reg[oq_wr_ptr2] <= s3_open_reg;
            oq_end_reg[oq_wr_ptr2]  <= 1'b1;
        end
    end

    assign bin_index  = oq_bin_reg[oq_rd_ptr_reg];
    assign mask_value = oq_mask_reg[oq_rd_ptr_reg];
    assign gate_state = oq_open_reg[oq_rd_ptr_reg];
    assign frame_end  = oq_end_reg[oq_rd_ptr_reg];

endmodule

`default_nettype wire

>>> src/spectral_gate_mask_engine.sv
// Top level of the spectral gate mask engine: configuration registers and block wiring.
//
// Usage:
//   Input channel: push a bin magnitude (Q8.16) while full is low; bins of a frame go
//   in order 0 to BIN_COUNT-1, frames follow back to back, the bin number is counted
//   inside. Result channel: while empty is low the oldest result (bin, Q1.15 mask,
//   gate, frame end) is on the ports; pop takes it.
//   Results run one bin behind the input: the result for bin k is ready once bin k+1 has
//   passed the input queue and the stage 1, 2 and 3 registers; the last bin of a frame
//   releases two results, the second with frame_end set. Bin 0 releases none.
//   Throughput: one bin per clock unless stalled, set by the three-stage
//   read-modify-write pipeline on the per-bin state RAM (one read and one write port).
//   The input queue holds four bins; the result queue holds four results and the
//   pipeline moves only while two of its slots are free. A stalled receiver thus fills
//   the result queue, then the input queue, and full goes high.
//   Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once and are
//   meant for idle periods. Reset loads the default registers, restarts at bin 0 and
//   treats every bin as closed with unity mask for the first frame; no clearing pass.
`default_nettype none

module spectral_gate_mask_engine #(
    parameter int FFT_POINTS = 1024,
    parameter int BIN_COUNT  = 513
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [sgme_pkg::MAG_W-1:0]          magnitude,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic      [$clog2(BIN_COUNT)-1:0]        bin_index,
    output logic      [sgme_pkg::MASK_W-1:0]         mask_value,
    output logic                                     gate_state,
    output logic                                     frame_end,
    input  wire logic                                cfg_wr_en,
    input  wire logic [sgme_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sgme_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int BinW     = $clog2(BIN_COUNT);
    localparam int ShiftLog = $clog2(FFT_POINTS);
    localparam int PW       = BinW + 19;
    localparam int WW       = (PW - ShiftLog > 14) ? (PW - ShiftLog) : 14;
    localparam int MagW     = sgme_pkg::MAG_W;
    localparam int ItemW    = MagW + BinW + WW + 2;
    localparam int QDepth   = 4;

    sgme_pkg::cfg_t        cfg_reg;

    logic                  f_push;
    logic [MagW-1:0]       f_mag;
    logic [BinW-1:0]       f_bin;
    logic [WW-1:0]         f_w;
    sgme_pkg::item_flags_t f_flags;
    logic [ItemW-1:0]      q_wdata;
    logic [ItemW-1:0]      q_rdata;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= sgme_pkg::CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (sgme_pkg::cfg_idx_t'(cfg_index))
                sgme_pkg::CFG_OPEN_THRESHOLD: cfg_reg.open_threshold <= cfg_data[23:0];
                sgme_pkg::CFG_CLOSED_GAIN:    cfg_reg.closed_gain    <= cfg_data[15:0];
                sgme_pkg::CFG_ATTACK_COEFF:   cfg_reg.attack_coeff   <= cfg_data[16:0];
                sgme_pkg::CFG_RELEASE_COEFF:  cfg_reg.release_coeff  <= cfg_data[16:0];
                sgme_pkg::CFG_FREQ_FACTOR:    cfg_reg.freq_factor    <= cfg_data[15:0];
                default:                      cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign full = q_full;

    sgme_front #(
        .FFT_POINTS (FFT_POINTS),
        .BIN_COUNT  (BIN_COUNT),
        .W_WIDTH    (WW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .magnitude   (magnitude),
        .freq_factor (cfg_reg.freq_factor),
        .q_full      (q_full),
        .q_push      (f_push),
        .q_mag       (f_mag),
        .q_bin       (f_bin),
        .q_w         (f_w),
        .q_flags     (f_flags)
    );

    // Pack one classified bin for the queue
    assign q_wdata = {f_mag, f_bin, f_w, f_flags};

    sgme_fifo #(
        .WIDTH (ItemW),
        .DEPTH (QDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    sgme_back #(
        .BIN_COUNT (BIN_COUNT),
        .W_WIDTH   (WW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_mag      (q_rdata[ItemW-1 -: MagW]),
        .q_bin      (q_rdata[ItemW-MagW-1 -: BinW]),
        .q_w        (q_rdata[WW+1:2]),
        .q_flags    (sgme_pkg::item_flags_t'(q_rdata[1:0])),
        .pop        (pop),
        .empty      (empty),
        .bin_index  (bin_index),
        .mask_value (mask_value),
        .gate_state (gate_state),
        .frame_end  (frame_end)
    );

endmodule

`default_nettype wire

>>> src/sgme_checker.sv
// Port-level checker of the spectral gate mask engine and its bind.
`default_nettype none

module sgme_checker #(
    parameter int BIN_COUNT = 513
) (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         full,
    input wire logic                         empty,
    input wire logic                         pop,
    input wire logic [$clog2(BIN_COUNT)-1:0] bin_index,
    input wire logic [15:0]                  mask_value,
    input wire logic                         frame_end
);

    localparam int BinW = $clog2(BIN_COUNT);

    logic            pop_ok;
    logic [BinW-1:0] exp_bin_reg;

    assign pop_ok = pop && !empty;

    // Track the bin expected on the next taken result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_bin_reg <= '0;
        end
        else if (pop_ok)
        begin
            exp_bin_reg <= frame_end ? '0 : bin_index + BinW'(1);
        end
    end

    // Nothing waits and input is open on the edge after one seen in reset
    a_reset_clear: assert property (@(posedge clk) !rst_n |=> (empty && !full))
        else $error("queues not cleared in reset");

    // Results leave in bin order, frame after frame
    a_bin_order: assert property (@(posedge clk) disable iff (!rst_n)
        pop_ok |-> (bin_index == exp_bin_reg))
        else $error("result out of bin order");

    // Frame end marks exactly the highest bin
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (frame_end == (bin_index == BinW'(BIN_COUNT - 1))))
        else $error("frame_end on wrong bin");

    // Mask never exceeds unity
    a_mask_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (mask_value <= 16'h8000))
        else $error("mask above unity");

    // A waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(bin_index) && $stable(mask_value)))
        else $error("waiting result changed");

endmodule

bind spectral_gate_mask_engine sgme_checker #(
    .BIN_COUNT (BIN_COUNT)
) u_sgme_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .bin_index  (bin_index),
    .mask_value (mask_value),
    .frame_end  (frame_end)
);

`default_nettype wire

>>> dv/sgme_mask_checker.sv
// Watches the spectral gate channels, predicts every bin mask and compares the results.
module sgme_mask_checker
    import sgme_pkg::*;
#(
    parameter int FFT_POINTS = 1024,
    parameter int BIN_COUNT  = 513
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic                          full,
    input  wire logic [MAG_W-1:0]              magnitude,
    input  wire logic                          empty,
    input  wire logic                          pop,
    input  wire logic [$clog2(BIN_COUNT)-1:0]  bin_index,
    input  wire logic [MASK_W-1:0]             mask_value,
    input  wire logic                          gate_state,
    input  wire logic                          frame_end,
    input  wire logic                          cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data,
    output int                                 mismatch_count,
    output int                                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  IDX_W       = $clog2(BIN_COUNT);
    localparam int  REPORT_MAX  = 10;
    localparam longint UNITY_Q15 = longint'(UNITY_MASK);
    localparam longint UNITY_Q16 = longint'(UNITY_COEFF);
    localparam longint UNITY_Q12 = longint'(UNITY_WEIGHT);
    localparam longint MAG_TOP   = longint'(MAG_MAX);

    typedef struct packed {
        logic [IDX_W-1:0]  bin;
        logic [MASK_W-1:0] mask;
        logic              open;
        logic              last;
    } bin_mask_t;

    // Shadow of the registers and the per-bin state
    cfg_t              regs;
    logic              gate_open [BIN_COUNT];
    logic [MASK_W-1:0] gain_mask [BIN_COUNT];
    logic [MASK_W-1:0] prev_mask [2];
    int                next_bin;
    bin_mask_t         expected_masks [$];
    int                mismatches;

    function automatic logic [MASK_W-1:0] median_of_three(
        input logic [MASK_W-1:0] a, input logic [MASK_W-1:0] b, input logic [MASK_W-1:0] c);
        if (a > b)
            return (b > c) ? b : ((a > c) ? c : a);
        return (a > c) ? a : ((b > c) ? c : b);
    endfunction

    function automatic longint clamp_magnitude(input longint v);
        if (v < 0)
            return 0;
        return (v > MAG_TOP) ? MAG_TOP : v;
    endfunction

    function automatic bin_mask_t make_result(
        input int b, input logic [MASK_W-1:0] m, input logic open, input logic last);
        bin_mask_t r;
        r.bin  = IDX_W'(b);
        r.mask = m;
        r.open = open;
        r.last = last;
        return r;
    endfunction

    // Update gate and mask of the current bin, queue the results it releases
    task automatic advance_bin(input logic [MAG_W-1:0] mag_in);
        longint weight, prod, thr_open, thr_close, mag, target, cur, coeff, delta;
        logic [MASK_W-1:0] m;
        int b;
        b      = next_bin;
        mag    = longint'(mag_in);
        weight = UNITY_Q12 +
                 ((longint'(regs.freq_factor) - UNITY_Q12) * 2 * b) / FFT_POINTS;
        if (weight < 0)
            weight = 0;
        prod      = longint'(regs.open_threshold) * weight;
        thr_open  = clamp_magnitude(prod / UNITY_Q12);
        thr_close = clamp_magnitude((prod * 7) / (10 * UNITY_Q12));

        // Hysteresis gate
        if (!gate_open[b] && mag > thr_open)
            gate_open[b] = 1'b1;
        else if (gate_open[b] && mag < thr_close)
            gate_open[b] = 1'b0;

        // Attack or release toward the target
        if (gate_open[b])
            target = UNITY_Q15;
        else
            target = (longint'(regs.closed_gain) > UNITY_Q15) ? UNITY_Q15
                                                              : longint'(regs.closed_gain);
        cur   = longint'(gain_mask[b]);
        coeff = (target > cur) ? longint'(regs.attack_coeff) : longint'(regs.release_coeff);
        if (coeff > UNITY_Q16)
            coeff = UNITY_Q16;
        delta = ((target - cur) * coeff) / UNITY_Q16;
        m     = MASK_W'(cur + delta);
        gain_mask[b] = m;

        // Previous bin leaves now; edge bins skip the median
        if (b == 1)
            expected_masks.push_back(make_result(0, prev_mask[1], gate_open[0], 1'b0));
        else if (b >= 2)
            expected_masks.push_back(make_result(b - 1,
                median_of_three(prev_mask[0], prev_mask[1], m), gate_open[b - 1], 1'b0));
        prev_mask[0] = prev_mask[1];
        prev_mask[1] = m;

        if (b + 1 >= BIN_COUNT)
        begin
            expected_masks.push_back(make_result(b, m, gate_open[b], 1'b1));
            next_bin = 0;
        end
        else
        begin
            next_bin = b + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bin_mask_t want;
        if (!rst_n)
        begin
            regs = CFG_RESET;
            for (int i = 0; i < BIN_COUNT; i++)
            begin
                gate_open[i] = 1'b0;
                gain_mask[i] = UNITY_MASK;
            end
            prev_mask[0] = '0;
            prev_mask[1] = '0;
            next_bin     = 0;
            mismatches   = 0;
            expected_masks.delete();
            mismatch_count <= 0;
            outstanding    <= 0;
        end
        else
        begin
            // Register writes; indexes past the map are dropped
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_OPEN_THRESHOLD: regs.open_threshold = cfg_data[MAG_W-1:0];
                    CFG_CLOSED_GAIN:    regs.closed_gain    = cfg_data[MASK_W-1:0];
                    CFG_ATTACK_COEFF:   regs.attack_coeff   = cfg_data[COEFF_W-1:0];
                    CFG_RELEASE_COEFF:  regs.release_coeff  = cfg_data[COEFF_W-1:0];
                    CFG_FREQ_FACTOR:    regs.freq_factor    = cfg_data[FF_W-1:0];
                    default: ;
                endcase
            end

            // Compare the popped result against the oldest expectation
            if (!empty && pop)
            begin
                if (expected_masks.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: unexpected result bin %0d mask %0d gate %0b end %0b",
                                 $realtime, bin_index, mask_value, gate_state, frame_end);
                end
                else
                begin
                    want = expected_masks.pop_front();
                    if (want.bin !== bin_index || want.mask !== mask_value ||
                        want.open !== gate_state || want.last !== frame_end)
                    begin
                        mismatches++;
                        // Fields in order: bin, mask, gate, frame end
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: expected %0d %0d %0b %0b, got %0d %0d %0b %0b",
                                     $realtime, want.bin, want.mask, want.open, want.last,
                                     bin_index, mask_value, gate_state, frame_end);
                    end
                end
            end

            // Predict for every accepted request
            if (push && !full)
                advance_bin(magnitude);

            mismatch_count <= mismatches;
            outstanding    <= expected_masks.size();
        end
    end

endmodule

>>> dv/tb_spectral_gate_mask_engine.sv
// Stimulus, clock, reset and verdict for the spectral gate mask engine.
module tb_spectral_gate_mask_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import sgme_pkg::*;

    localparam int     FFT_POINTS    = 1024;
    localparam int     BIN_COUNT     = 513;
    localparam int     IDX_W         = $clog2(BIN_COUNT);
    localparam int     RANDOM_ITEMS  = 2000;
    localparam int     SETTLE_CYCLES = 20;
    localparam int     CORNER_COUNT  = 5;
    localparam longint TIMEOUT_NS    = 40_000_000;
    localparam longint MAG_TOP       = longint'(MAG_MAX);
    localparam longint UNITY_Q12     = longint'(UNITY_WEIGHT);
    localparam int     IDX_LAST      = (1 << CFG_IDX_W) - 1;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  push       = 1'b0;
    logic                  full;
    logic [MAG_W-1:0]      magnitude  = '0;
    logic                  empty;
    logic                  pop        = 1'b0;
    logic [IDX_W-1:0]      bin_index;
    logic [MASK_W-1:0]     mask_value;
    logic                  gate_state;
    logic                  frame_end;
    logic                  cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    int                    mismatch_count;
    int                    outstanding;

    // Stimulus-side copy of the settings and the bin being fed
    cfg_t live_cfg = CFG_RESET;
    int   feed_bin = 0;

    spectral_gate_mask_engine #(
        .FFT_POINTS (FFT_POINTS),
        .BIN_COUNT  (BIN_COUNT)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .magnitude  (magnitude),
        .empty      (empty),
        .pop        (pop),
        .bin_index  (bin_index),
        .mask_value (mask_value),
        .gate_state (gate_state),
        .frame_end  (frame_end),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    sgme_mask_checker #(
        .FFT_POINTS (FFT_POINTS),
        .BIN_COUNT  (BIN_COUNT)
    ) mask_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .magnitude      (magnitude),
        .empty          (empty),
        .pop            (pop),
        .bin_index      (bin_index),
        .mask_value     (mask_value),
        .gate_state     (gate_state),
        .frame_end      (frame_end),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Weighted open and close levels of a bin under the live settings
    function automatic void bin_levels(input int b, output longint lvl_open,
                                       output longint lvl_close);
        longint weight, prod;
        weight = UNITY_Q12 + ((longint'(live_cfg.freq_factor) - UNITY_Q12) * 2 * b) / FFT_POINTS;
        if (weight < 0)
            weight = 0;
        prod      = longint'(live_cfg.open_threshold) * weight;
        lvl_open  = (prod / UNITY_Q12 > MAG_TOP) ? MAG_TOP : prod / UNITY_Q12;
        lvl_close = ((prod * 7) / (10 * UNITY_Q12) > MAG_TOP) ? MAG_TOP
                                                               : (prod * 7) / (10 * UNITY_Q12);
    endfunction

    // Aim nearly half of the magnitudes at the hysteresis edges of the current bin
    function automatic logic [MAG_W-1:0] pick_magnitude();
        longint lvl_open, lvl_close, m;
        int r;
        bin_levels(feed_bin, lvl_open, lvl_close);
        r = $urandom_range(0, 99);
        if (r < 25)
            m = lvl_open + longint'($urandom_range(0, 4)) - 2;
        else if (r < 45)
            m = lvl_close + longint'($urandom_range(0, 4)) - 2;
        else if (r < 60)
            m = lvl_open + longint'($urandom_range(0, 1 << 20));
        else if (r < 75)
            m = longint'($urandom_range(0, int'(lvl_close)));
        else if (r < 90)
            m = longint'($urandom) & MAG_TOP;
        else if (r < 95)
            m = 0;
        else
            m = MAG_TOP;
        if (m < 0)
            m = 0;
        if (m > MAG_TOP)
            m = MAG_TOP;
        return MAG_W'(m);
    endfunction

    function automatic cfg_t corner_settings(input int k);
        cfg_t s;
        case (k)
            0: begin
                s.open_threshold = '0;
                s.closed_gain    = '0;
                s.attack_coeff   = '0;
                s.release_coeff  = '0;
                s.freq_factor    = 16'd410;
            end
            1: begin
                s.open_threshold = MAG_MAX;
                s.closed_gain    = UNITY_MASK;
                s.attack_coeff   = UNITY_COEFF;
                s.release_coeff  = UNITY_COEFF;
                s.freq_factor    = 16'd40960;
            end
            2: begin
                s.open_threshold = 24'd3000000;
                s.closed_gain    = '1;
                s.attack_coeff   = '1;
                s.release_coeff  = '1;
                s.freq_factor    = '1;
            end
            3: begin
                s.open_threshold = 24'd100000;
                s.closed_gain    = 16'd16384;
                s.attack_coeff   = 17'd30000;
                s.release_coeff  = 17'd5000;
                s.freq_factor    = '0;
            end
            default: s = CFG_RESET;
        endcase
        return s;
    endfunction

    function automatic logic [COEFF_W-1:0] random_coeff();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return COEFF_W'($urandom_range(65537, 131071));
        if (r == 1)
            return ($urandom_range(0, 1) == 0) ? '0 : UNITY_COEFF;
        return COEFF_W'($urandom_range(0, 65536));
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        case ($urandom_range(0, 2))
            0: s.open_threshold = MAG_W'($urandom_range(0, 1000));
            1: s.open_threshold = MAG_W'($urandom_range(0, 200000));
            default: s.open_threshold = MAG_W'($urandom);
        endcase
        s.closed_gain = ($urandom_range(0, 9) == 0) ? MASK_W'($urandom_range(32769, 65535))
                                                    : MASK_W'($urandom_range(0, 32768));
        s.attack_coeff  = random_coeff();
        s.release_coeff = random_coeff();
        s.freq_factor   = ($urandom_range(0, 9) == 0) ? FF_W'($urandom)
                                                      : FF_W'($urandom_range(410, 40960));
        return s;
    endfunction

    // Drive one request and hold it until taken
    task automatic send_mag(input logic [MAG_W-1:0] mag, input int gap);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        magnitude <= mag;
        @(posedge clk);
        while (full)
            @(posedge clk);
        feed_bin = (feed_bin + 1 == BIN_COUNT) ? 0 : feed_bin + 1;
    endtask

    // Drop push, wait for every result, then let the pipeline drain
    task automatic settle();
        push <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Write all registers, with junk in the unused upper bits and one stray index
    task automatic load_settings(input cfg_t s);
        put_reg(CFG_OPEN_THRESHOLD, s.open_threshold);
        put_reg(CFG_CLOSED_GAIN, {8'($urandom), s.closed_gain});
        put_reg(CFG_ATTACK_COEFF, {7'($urandom), s.attack_coeff});
        put_reg(CFG_RELEASE_COEFF, {7'($urandom), s.release_coeff});
        put_reg(CFG_FREQ_FACTOR, {8'($urandom), s.freq_factor});
        put_reg(CFG_IDX_W'($urandom_range(CFG_FREQ_FACTOR + 1, IDX_LAST)),
                CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
        live_cfg = s;
    endtask

    // Result side: random stalls with occasional long runs of steady pop
    initial
    begin
        int stall;
        int burst;
        @(posedge rst_n);
        forever begin
            if ($urandom_range(0, 9) == 0) begin
                pop   <= 1'b1;
                burst = $urandom_range(50, 200);
            end
            else begin
                stall = gap_len();
                if (stall > 0) begin
                    pop <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                pop   <= 1'b1;
                burst = $urandom_range(1, 4);
            end
            repeat (burst) @(posedge clk);
        end
    end

    initial
    begin
        longint lvl_open, lvl_close;
        logic [MAG_W-1:0] opening [$];
        int fed;
        int phase;
        int phase_len;
        bit steady;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed start of the first frame: field extremes and both gate edges
        bin_levels(0, lvl_open, lvl_close);
        opening = '{'0, MAG_MAX, MAG_W'(lvl_open), MAG_W'(lvl_open + 1),
                    MAG_W'(lvl_open - 1), MAG_W'(lvl_close), MAG_W'(lvl_close - 1),
                    MAG_W'(lvl_close + 1), 24'd1, 24'hAAAAAA, 24'h555555, 24'h800000,
                    24'h7FFFFF, '0, MAG_MAX, '0};
        foreach (opening[i])
            send_mag(opening[i], (i < 8) ? 0 : gap_len());

        // Random phases, settings changed only while idle
        fed   = 0;
        phase = 0;
        while (fed < RANDOM_ITEMS) begin
            settle();
            load_settings((phase < CORNER_COUNT) ? corner_settings(phase) : random_settings());
            steady    = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(100, 400);
            repeat (phase_len)
                send_mag(pick_magnitude(), steady ? 0 : gap_len());
            fed   += phase_len;
            phase++;
        end
        settle();

        if (mismatch_count == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> spectral_gate_mask_engine.f
src/sgme_pkg.sv
src/sgme_ram.sv
src/sgme_fifo.sv
src/sgme_front.sv
src/sgme_back.sv
src/spectral_gate_mask_engine.sv
src/sgme_checker.sv
dv/sgme_mask_checker.sv
dv/tb_spectral_gate_mask_engine.sv
